// ===== src/phsm_pkg.sv =====
// shared types and constants for the packet handle slot manager
package phsm_pkg;

    localparam int KIND_W     = 2;
    localparam int HANDLE_W   = 32;
    localparam int TIME_W     = 32;
    localparam int SLOT_OUT_W = 8;
    localparam int STATUS_W   = 2;
    localparam int HOLD_W     = 8;
    localparam int APB_AW     = 2;
    localparam int APB_DW     = 32;

    localparam logic [KIND_W-1:0] KIND_SAVE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETRIEVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISCARD  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BUSY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

    localparam logic [APB_AW-1:0] ADDR_HOLD  = 2'd0;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd1;

    // controller to datapath
    typedef struct packed {
        logic clear;   // write one zero entry of the clearing pass
        logic accept;  // latch the input beat and start the table read
        logic commit;  // write back and load the output register
    } phsm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass is on its last entry
        logic out_free;    // output register can take a result this cycle
    } phsm_stat_t;

endpackage

// ===== src/packet_handle_slot_manager_core.sv =====
// top level: stream ports, hold-time register and controller/datapath wiring
//
// Issues 32-bit handles {cookie, slot} for parked packets. Each item has a
// registered read of the slot table at accept, then the compare, cookie bump
// and write-back into the table at commit, with s_tready low in between.
// The next beat is taken while a finished result waits in the output register;
// the block stalls only when that register is still full at commit. After
// reset the table is cleared one entry per cycle, all 2**SLOT_BITS entries, with
// s_tready low; hold_seconds may be written during that time. The slot field
// carries the low 8 bits of the slot index.
module packet_handle_slot_manager_core
#(
    parameter int SLOT_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // handle[31:0], now_seconds[63:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // handle_out[31:0], slot[39:32], status[41:40],
                                   // released_old[42], zero[47:43]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    phsm_pkg::phsm_cmd_t  cmd;
    phsm_pkg::phsm_stat_t stat;

    logic [phsm_pkg::HOLD_W-1:0]     hold_reg;
    logic [phsm_pkg::HANDLE_W-1:0]   handle_out;
    logic [phsm_pkg::SLOT_OUT_W-1:0] slot;
    logic [phsm_pkg::STATUS_W-1:0]   status;
    logic                            released_old;
    logic                            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= phsm_pkg::HOLD_RESET;
        end
        else if (cfg_write && (paddr == phsm_pkg::ADDR_HOLD))
        begin
            hold_reg <= pwdata[phsm_pkg::HOLD_W-1:0];
        end
    end

    assign prdata = (paddr == phsm_pkg::ADDR_HOLD) ? phsm_pkg::APB_DW'(hold_reg) : '0;

    phsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    phsm_datapath
    #(
        .SLOT_BITS (SLOT_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .hold_seconds (hold_reg),
        .kind         (s_tuser),
        .handle       (s_tdata[31:0]),
        .now_seconds  (s_tdata[63:32]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .handle_out   (handle_out),
        .slot         (slot),
        .status       (status),
        .released_old (released_old)
    );

    assign m_tdata = {5'b0, released_old, status, slot, handle_out};

endmodule

// ===== src/phsm_ctrl.sv =====
// sequencer: clearing pass, then accept / lookup-and-commit per item
module phsm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  phsm_pkg::phsm_stat_t stat,
    output phsm_pkg::phsm_cmd_t  cmd
);

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold the result until the output register drains
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/phsm_datapath.sv =====
// slot table, round-robin pointer, save/release logic and output register
module phsm_datapath
#(
    parameter int SLOT_BITS = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  phsm_pkg::phsm_cmd_t                   cmd,
    output phsm_pkg::phsm_stat_t                  stat,
    input  logic [phsm_pkg::HOLD_W-1:0]           hold_seconds,
    input  logic [phsm_pkg::KIND_W-1:0]           kind,
    input  logic [phsm_pkg::HANDLE_W-1:0]         handle,
    input  logic [phsm_pkg::TIME_W-1:0]           now_seconds,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [phsm_pkg::HANDLE_W-1:0]         handle_out,
    output logic [phsm_pkg::SLOT_OUT_W-1:0]       slot,
    output logic [phsm_pkg::STATUS_W-1:0]         status,
    output logic                                  released_old
);

    localparam int COOKIE_W = phsm_pkg::HANDLE_W - SLOT_BITS;
    localparam int DEPTH    = 1 << SLOT_BITS;
    localparam int ENTRY_W  = 1 + COOKIE_W + phsm_pkg::TIME_W;

    // entry: {occupied, cookie, expiry}
    logic [ENTRY_W-1:0] mem [DEPTH];

    logic [SLOT_BITS-1:0]             clr_reg;
    logic [SLOT_BITS-1:0]             next_slot_reg;
    logic [SLOT_BITS-1:0]             slot_reg;
    logic [phsm_pkg::KIND_W-1:0]      kind_reg;
    logic [COOKIE_W-1:0]              cookie_in_reg;
    logic [phsm_pkg::TIME_W-1:0]      now_reg;
    logic [ENTRY_W-1:0]               rd_reg;

    logic                             out_valid_reg;
    logic [phsm_pkg::HANDLE_W-1:0]    handle_out_reg;
    logic [phsm_pkg::SLOT_OUT_W-1:0]  slot_out_reg;
    logic [phsm_pkg::STATUS_W-1:0]    status_reg;
    logic                             released_reg;

    logic [SLOT_BITS-1:0]             rd_addr;
    logic                             ent_occ;
    logic [COOKIE_W-1:0]              ent_cookie;
    logic [phsm_pkg::TIME_W-1:0]      ent_expiry;
    logic [COOKIE_W-1:0]              cookie_inc;
    logic [COOKIE_W-1:0]              cookie_new;
    logic [phsm_pkg::TIME_W:0]        expiry_sum;
    logic [phsm_pkg::TIME_W-1:0]      expiry_new;
    logic [phsm_pkg::HANDLE_W-1:0]    slot_wide;

    logic                             wb_en;
    logic [ENTRY_W-1:0]               wb_data;
    logic [phsm_pkg::HANDLE_W-1:0]    res_handle;
    logic [phsm_pkg::SLOT_OUT_W-1:0]  res_slot;
    logic [phsm_pkg::STATUS_W-1:0]    res_status;
    logic                             res_released;

    logic                             mem_we;
    logic [SLOT_BITS-1:0]             mem_waddr;
    logic [ENTRY_W-1:0]               mem_wdata;

    assign rd_addr = (kind == phsm_pkg::KIND_SAVE) ? (next_slot_reg + 1'b1)
                                                   : handle[SLOT_BITS-1:0];

    assign {ent_occ, ent_cookie, ent_expiry} = rd_reg;

    // cookie never reaches all ones, so an issued handle is never all ones; all ones is returned on a busy save
    assign cookie_inc = ent_cookie + 1'b1;
    assign cookie_new = (&cookie_inc) ? '0 : cookie_inc;

    assign expiry_sum = {1'b0, now_reg}
                      + (phsm_pkg::TIME_W + 1)'(hold_seconds);
    assign expiry_new = expiry_sum[phsm_pkg::TIME_W] ? '1
                                                     : expiry_sum[phsm_pkg::TIME_W-1:0];

    assign slot_wide = phsm_pkg::HANDLE_W'(slot_reg);

    always_comb
    begin
        wb_en        = 1'b0;
        wb_data      = rd_reg;
        res_handle   = '0;
        res_slot     = slot_wide[phsm_pkg::SLOT_OUT_W-1:0];
        res_status   = phsm_pkg::STATUS_OK;
        res_released = 1'b0;
        case (kind_reg)
            phsm_pkg::KIND_SAVE:
            begin
                if (ent_occ && (now_reg < ent_expiry))
                begin
                    res_handle = '1;
                    res_status = phsm_pkg::STATUS_BUSY;
                end
                else
                begin
                    wb_en        = 1'b1;
                    wb_data      = {1'b1, cookie_new, expiry_new};
                    res_handle   = {cookie_new, slot_reg};
                    res_released = ent_occ;
                end
            end
            phsm_pkg::KIND_RETRIEVE, phsm_pkg::KIND_DISCARD:
            begin
                if (ent_cookie != cookie_in_reg)
                begin
                    res_status = phsm_pkg::STATUS_MISMATCH;
                end
                else if (!ent_occ)
                begin
                    res_status = phsm_pkg::STATUS_EMPTY;
                end
                else
                begin
                    wb_en   = 1'b1;
                    wb_data = {1'b0, ent_cookie, ent_expiry};
                end
            end
            default:
            begin
                res_slot = '0;
            end
        endcase
    end

    assign mem_we    = cmd.clear || (cmd.commit && wb_en);
    assign mem_waddr = cmd.clear ? clr_reg : slot_reg;
    assign mem_wdata = cmd.clear ? '0 : wb_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // latched item fields and the output register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg      <= rd_addr;
            kind_reg      <= kind;
            cookie_in_reg <= handle[phsm_pkg::HANDLE_W-1:SLOT_BITS];
            now_reg       <= now_seconds;
        end
        if (cmd.commit)
        begin
            handle_out_reg <= res_handle;
            slot_out_reg   <= res_slot;
            status_reg     <= res_status;
            released_reg   <= res_released;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            next_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            // pointer advances even when the save is refused
            if (cmd.accept && (kind == phsm_pkg::KIND_SAVE))
            begin
                next_slot_reg <= rd_addr;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = &clr_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign handle_out   = handle_out_reg;
    assign slot         = slot_out_reg;
    assign status       = status_reg;
    assign released_old = released_reg;

endmodule
